@@ hw/rtl/source_text_comment_stripper_macros.svh @@
// ---------------------------------------------------------------------------
// Comment stripper assertion macros
// Concurrent check helpers; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_COMMENT_STRIPPER_MACROS_SVH
`define SOURCE_TEXT_COMMENT_STRIPPER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during rst.
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CTS_ASSERT_IMP(lbl, ante, cons, msg)
`define CTS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ hw/rtl/cts_pkg.sv @@
// ---------------------------------------------------------------------------
// Comment stripper package
// Character codes, result kinds, scan state and result bundle types.
// ---------------------------------------------------------------------------
package cts_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Most results one byte can cause.
  localparam int MAX_RES   = 4;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W = $clog2(MAX_RES);

  // Bundles buffered between front and back; power of two, at least 2.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END_OK   = 2'd1,
    KIND_END_OPEN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_BLOCK = 2'd2
  } mode_t;

  typedef struct packed {
    logic  after_cr;
    logic  held_bsl;
    mode_t mode;
    logic  held_slash;
    logic  held_star;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   items;
    logic [RES_CNT_W-1:0] count;
  } bundle_t;

endpackage

@@ hw/rtl/cts_in_if.sv @@
// ---------------------------------------------------------------------------
// Comment stripper input channel
// Raw source bytes with an end-of-text flag, valid/ready handshake.
// ---------------------------------------------------------------------------
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

@@ hw/rtl/cts_out_if.sv @@
// ---------------------------------------------------------------------------
// Comment stripper output channel
// Filtered bytes and end-of-text status, valid/ready handshake.
// ---------------------------------------------------------------------------
interface cts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] kind;
  logic       run_last;

  modport source (output valid, output char_out, output kind, output run_last,
                  input ready);
  modport sink   (input valid, input char_out, input kind, input run_last,
                  output ready);
endinterface

@@ hw/rtl/source_text_comment_stripper.sv @@
// ---------------------------------------------------------------------------
// Source text comment stripper
// Folds newlines, splices backslash-newline and replaces comments by spaces.
// ---------------------------------------------------------------------------
// Usage:
//   text_in  (sink)   : one raw source byte per request in char_in, with
//                       end_of_text set on the final byte of a text.
//   text_out (source) : filtered results; kind is byte, end ok, or end with
//                       an open block comment. run_last flags the final
//                       result caused by one input byte. A byte that is
//                       absorbed (held slash, backslash, comment body, LF
//                       of CR LF) causes no result at all.
//   Path     : a byte's bundle is registered in the queue, then in cts_back.
//   Throughput: a byte can be taken every cycle while the bundle queue has
//                room; the back end drains one result a cycle while
//                text_out.ready is high, so a byte that causes several
//                results (up to four) holds the output for each of them.
//                Typical text sustains one byte a cycle when unstalled.
//   Stall    : when text_out.ready is low the back end holds its result,
//                the queue fills, then text_in.ready drops. Nothing is lost.
//   Reset    : rst (synchronous) clears scan state, queue and output; after
//                end_of_text the scanner returns to reset state on its own.
// ---------------------------------------------------------------------------
`include "source_text_comment_stripper_macros.svh"

module source_text_comment_stripper #(
  parameter int QueueDepth = cts_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  cts_in_if.sink    text_in,
  cts_out_if.source text_out
);

  // front to queue
  logic                 push;
  cts_pkg::bundle_t     push_data;
  logic                 q_full;
  cts_pkg::scan_state_t scan_state;

  // queue to back
  logic                 pop;
  logic                 q_not_empty;
  cts_pkg::bundle_t     pop_data;

  // Front: classifies each byte and builds its result bundle combinationally.
  cts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .queue_full (q_full),
    .push       (push),
    .push_data  (push_data),
    .state      (scan_state)
  );

  // Queue: decouples byte intake from result delivery.
  cts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  // Back: serializes bundles onto the output channel.
  cts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .text_out  (text_out)
  );

  // End results are always the last of their byte and carry a zero byte.
  `CTS_ASSERT_IMP(a_end_is_last, text_out.valid && text_out.kind != cts_pkg::KIND_BYTE, text_out.run_last && text_out.char_out == 8'h00, "end result not last or nonzero")
  // The front never writes a full queue.
  `CTS_ASSERT_IMP(a_no_overflow, push, !q_full, "push into full queue")
  // The final byte of a text leaves the scanner in its reset state.
  `CTS_ASSERT_NXT(a_eot_clears, text_in.valid && text_in.ready && text_in.end_of_text, scan_state == '0, "scan state not cleared after end of text")
  // Every accepted final byte produces a bundle.
  `CTS_ASSERT_IMP(a_eot_pushes, text_in.valid && text_in.ready && text_in.end_of_text, push, "end of text without result")

endmodule

@@ hw/rtl/cts_front.sv @@
// ---------------------------------------------------------------------------
// Comment stripper front end
// Takes one byte per request, runs newline folding, splicing and comment
// removal, and pushes the resulting bundle of up to four results, if any.
// ---------------------------------------------------------------------------
module cts_front (
  input  logic                  clk,
  input  logic                  rst,
  cts_in_if.sink                text_in,
  input  logic                  queue_full,
  output logic                  push,
  output cts_pkg::bundle_t      push_data,
  output cts_pkg::scan_state_t  state
);

  typedef struct packed {
    cts_pkg::scan_state_t st;
    cts_pkg::bundle_t     b;
  } step_t;

  function automatic step_t emit(step_t s, logic [7:0] ch, cts_pkg::kind_t k);
    step_t r;
    r = s;
    if (s.b.count < cts_pkg::RES_CNT_W'(cts_pkg::MAX_RES)) begin
      r.b.items[s.b.count[cts_pkg::RES_IDX_W-1:0]] = '{ch: ch, kind: k};
      r.b.count = s.b.count + 1'b1;
    end
    return r;
  endfunction

  function automatic step_t comment_feed(step_t s, logic [7:0] c);
    step_t r;
    logic  go;
    r  = s;
    go = 1'b0;
    if (s.st.mode == cts_pkg::MODE_LINE) begin
      if (c == cts_pkg::CH_LF) begin
        r.st.mode = cts_pkg::MODE_CODE;
        r = emit(r, c, cts_pkg::KIND_BYTE);
      end
    end else if (s.st.mode == cts_pkg::MODE_BLOCK) begin
      if (s.st.held_star && c == cts_pkg::CH_SLASH) begin
        r.st.mode      = cts_pkg::MODE_CODE;
        r.st.held_star = 1'b0;
      end else begin
        r.st.held_star = (c == cts_pkg::CH_STAR);
      end
    end else begin
      go = 1'b1;
      if (s.st.held_slash) begin
        r.st.held_slash = 1'b0;
        if (c == cts_pkg::CH_SLASH) begin
          r.st.mode = cts_pkg::MODE_LINE;
          r  = emit(r, cts_pkg::CH_SPACE, cts_pkg::KIND_BYTE);
          go = 1'b0;
        end else if (c == cts_pkg::CH_STAR) begin
          r.st.mode      = cts_pkg::MODE_BLOCK;
          r.st.held_star = 1'b0;
          r  = emit(r, cts_pkg::CH_SPACE, cts_pkg::KIND_BYTE);
          go = 1'b0;
        end else begin
          r = emit(r, cts_pkg::CH_SLASH, cts_pkg::KIND_BYTE);
        end
      end
      if (go) begin
        if (c == cts_pkg::CH_SLASH) begin
          r.st.held_slash = 1'b1;
        end else begin
          r = emit(r, c, cts_pkg::KIND_BYTE);
        end
      end
    end
    return r;
  endfunction

  function automatic step_t splice_feed(step_t s, logic [7:0] c);
    step_t r;
    r = s;
    if (s.st.held_bsl) begin
      if (c == cts_pkg::CH_LF) begin
        r.st.held_bsl = 1'b0;
      end else if (c == cts_pkg::CH_BSL) begin
        r = comment_feed(r, cts_pkg::CH_BSL);
      end else begin
        r.st.held_bsl = 1'b0;
        r = comment_feed(r, cts_pkg::CH_BSL);
        r = comment_feed(r, c);
      end
    end else if (c == cts_pkg::CH_BSL) begin
      r.st.held_bsl = 1'b1;
    end else begin
      r = comment_feed(r, c);
    end
    return r;
  endfunction

  step_t s0;
  step_t s1;
  step_t s2;
  logic  accept;

  always_comb begin
    s0      = '0;
    s0.st   = state;
    s1      = s0;
    s2      = s0;
    // newline folding
    if (text_in.char_in == cts_pkg::CH_CR) begin
      s1.st.after_cr = 1'b1;
      s1 = splice_feed(s1, cts_pkg::CH_LF);
    end else if (text_in.char_in == cts_pkg::CH_LF && state.after_cr) begin
      s1.st.after_cr = 1'b0;
    end else begin
      s1.st.after_cr = 1'b0;
      s1 = splice_feed(s1, text_in.char_in);
    end
    // end-of-text flush
    s2 = s1;
    if (text_in.end_of_text) begin
      if (s2.st.held_bsl) begin
        s2.st.held_bsl = 1'b0;
        s2 = comment_feed(s2, cts_pkg::CH_BSL);
      end
      if (s2.st.held_slash && s2.st.mode != cts_pkg::MODE_LINE &&
          s2.st.mode != cts_pkg::MODE_BLOCK) begin
        s2.st.held_slash = 1'b0;
        s2 = emit(s2, cts_pkg::CH_SLASH, cts_pkg::KIND_BYTE);
      end
      s2 = emit(s2, 8'h00, (s2.st.mode == cts_pkg::MODE_BLOCK) ?
                cts_pkg::KIND_END_OPEN : cts_pkg::KIND_END_OK);
      s2.st = '0;
    end
  end

  assign text_in.ready = !queue_full;
  assign accept        = text_in.valid && text_in.ready;
  assign push          = accept && (s2.b.count != '0);
  assign push_data     = s2.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= s2.st;
    end
  end

endmodule

@@ hw/rtl/cts_queue.sv @@
// ---------------------------------------------------------------------------
// Comment stripper bundle queue
// Small FIFO of result bundles between the front and back ends.
// ---------------------------------------------------------------------------
module cts_queue #(
  parameter int Depth = cts_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cts_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output cts_pkg::bundle_t pop_data
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cts_pkg::bundle_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/cts_back.sv @@
// ---------------------------------------------------------------------------
// Comment stripper back end
// Unpacks one bundle at a time to text_out; one result a cycle when ready.
// ---------------------------------------------------------------------------
module cts_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             not_empty,
  input  cts_pkg::bundle_t pop_data,
  output logic             pop,
  cts_out_if.source        text_out
);

  cts_pkg::bundle_t              cur;
  logic                          cur_valid;
  logic [cts_pkg::RES_IDX_W-1:0] idx;
  logic                          last;
  logic                          advance;
  logic                          take;
  cts_pkg::res_t                 item;

  assign item    = cur.items[idx];
  assign last    = ({1'b0, idx} == (cur.count - 1'b1));
  assign advance = text_out.valid && text_out.ready;
  assign take    = !cur_valid || (advance && last);
  assign pop     = take && not_empty;

  assign text_out.valid    = cur_valid;
  assign text_out.char_out = item.ch;
  assign text_out.kind     = item.kind;
  assign text_out.run_last = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      cur_valid <= not_empty;
      idx       <= '0;
    end else if (advance) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

@@ tb/cts_checker.sv @@
// ---------------------------------------------------------------------------
// Comment stripper checker
// Watches both channels, predicts the filtered stream of every accepted
// source byte and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
module cts_checker (
  input  logic clk,
  input  logic rst,
  cts_in_if    text_in,
  cts_out_if   text_out,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]      ch;
    cts_pkg::kind_t  kind;
    logic            last;
  } filtered_t;

  // Predicted scanner state.
  logic           after_cr;
  logic           held_bsl;
  cts_pkg::mode_t cmt_mode;
  logic           held_slash;
  logic           held_star;

  cts_pkg::res_t step_res[$];
  filtered_t     pending_results[$];

  function void clear_scan();
    after_cr   = 1'b0;
    held_bsl   = 1'b0;
    cmt_mode   = cts_pkg::MODE_CODE;
    held_slash = 1'b0;
    held_star  = 1'b0;
  endfunction

  function void put_result(input logic [7:0] ch, input cts_pkg::kind_t k);
    cts_pkg::res_t r;
    if (step_res.size() < cts_pkg::MAX_RES) begin
      r.ch   = ch;
      r.kind = k;
      step_res.insert(step_res.size(), r);
    end
  endfunction

  // Phase 3: comment replacement.
  function void strip_comment(input logic [7:0] c);
    if (cmt_mode == cts_pkg::MODE_LINE) begin
      if (c == cts_pkg::CH_LF) begin
        cmt_mode = cts_pkg::MODE_CODE;
        put_result(c, cts_pkg::KIND_BYTE);
      end
      return;
    end
    if (cmt_mode == cts_pkg::MODE_BLOCK) begin
      if (held_star && c == cts_pkg::CH_SLASH) begin
        cmt_mode  = cts_pkg::MODE_CODE;
        held_star = 1'b0;
      end else begin
        held_star = (c == cts_pkg::CH_STAR);
      end
      return;
    end
    if (held_slash) begin
      held_slash = 1'b0;
      if (c == cts_pkg::CH_SLASH) begin
        cmt_mode = cts_pkg::MODE_LINE;
        put_result(cts_pkg::CH_SPACE, cts_pkg::KIND_BYTE);
        return;
      end
      if (c == cts_pkg::CH_STAR) begin
        cmt_mode  = cts_pkg::MODE_BLOCK;
        held_star = 1'b0;
        put_result(cts_pkg::CH_SPACE, cts_pkg::KIND_BYTE);
        return;
      end
      put_result(cts_pkg::CH_SLASH, cts_pkg::KIND_BYTE);
    end
    if (c == cts_pkg::CH_SLASH) held_slash = 1'b1;
    else put_result(c, cts_pkg::KIND_BYTE);
  endfunction

  // Phase 2: backslash-newline splicing.
  function void splice_line(input logic [7:0] c);
    if (held_bsl) begin
      if (c == cts_pkg::CH_LF) begin
        held_bsl = 1'b0;
      end else if (c == cts_pkg::CH_BSL) begin
        strip_comment(cts_pkg::CH_BSL);
      end else begin
        held_bsl = 1'b0;
        strip_comment(cts_pkg::CH_BSL);
        strip_comment(c);
      end
    end else if (c == cts_pkg::CH_BSL) begin
      held_bsl = 1'b1;
    end else begin
      strip_comment(c);
    end
  endfunction

  function void predict_byte(input logic [7:0] c, input logic eot);
    filtered_t f;
    step_res.delete();
    // Phase 1: CR LF and lone CR fold to LF.
    if (c == cts_pkg::CH_CR) begin
      after_cr = 1'b1;
      splice_line(cts_pkg::CH_LF);
    end else if (c == cts_pkg::CH_LF && after_cr) begin
      after_cr = 1'b0;
    end else begin
      after_cr = 1'b0;
      splice_line(c);
    end
    if (eot) begin
      if (held_bsl) begin
        held_bsl = 1'b0;
        strip_comment(cts_pkg::CH_BSL);
      end
      if (held_slash && cmt_mode != cts_pkg::MODE_LINE &&
          cmt_mode != cts_pkg::MODE_BLOCK) begin
        held_slash = 1'b0;
        put_result(cts_pkg::CH_SLASH, cts_pkg::KIND_BYTE);
      end
      put_result(8'h00, (cmt_mode == cts_pkg::MODE_BLOCK) ?
                 cts_pkg::KIND_END_OPEN : cts_pkg::KIND_END_OK);
      clear_scan();
    end
    foreach (step_res[i]) begin
      f.ch   = step_res[i].ch;
      f.kind = step_res[i].kind;
      f.last = (i == step_res.size() - 1);
      pending_results.insert(pending_results.size(), f);
    end
  endfunction

  always @(posedge clk) begin
    filtered_t want;
    if (rst) begin
      clear_scan();
      pending_results.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (text_out.valid && text_out.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result expected none actual ch=%02h kind=%0d last=%0b",
                   $time, text_out.char_out, text_out.kind, text_out.run_last);
        end else begin
          want = pending_results.pop_front();
          if (text_out.char_out !== want.ch) begin
            fail_count++;
            $display("%0t: char_out mismatch expected %02h actual %02h",
                     $time, want.ch, text_out.char_out);
          end
          if (text_out.kind !== want.kind) begin
            fail_count++;
            $display("%0t: kind mismatch expected %0d actual %0d",
                     $time, want.kind, text_out.kind);
          end
          if (text_out.run_last !== want.last) begin
            fail_count++;
            $display("%0t: run_last mismatch expected %0b actual %0b",
                     $time, want.last, text_out.run_last);
          end
        end
      end
      if (text_in.valid && text_in.ready)
        predict_byte(text_in.char_in, text_in.end_of_text);
      outstanding <= pending_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// Comment stripper testbench
// Directed texts for newline folding, splicing and both comment forms, then
// random token-built texts under four idle/stall regimes; the checker does
// the prediction and comparison.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no request on either side before the run is called hung.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int BYTES_PER_PHASE = 55;

  logic clk;
  logic rst;

  cts_in_if  text_in();
  cts_out_if text_out();

  int fail_count;
  int outstanding;
  int src_idle_pct;
  int sink_stall_pct;
  int bytes_sent;
  int quiet_cycles;

  logic [7:0] text_bytes[$];

  source_text_comment_stripper u_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .text_out (text_out)
  );

  cts_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_in),
    .text_out    (text_out),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver side: ready drops at random per the current stall rate.
  always @(posedge clk) begin
    if (rst) begin
      text_out.ready <= 1'b0;
    end else begin
      text_out.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (text_in.valid && text_in.ready) || (text_out.valid && text_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // One request on the input side. An idle gap, if drawn, lowers valid in
  // the step of the previous handshake; otherwise valid stays high and only
  // the payload changes, so valid never gets two updates in one step.
  task automatic send_byte(input logic [7:0] ch, input logic last_byte);
    while ($urandom_range(99) < src_idle_pct) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid       <= 1'b1;
    text_in.char_in     <= ch;
    text_in.end_of_text <= last_byte;
    do @(posedge clk); while (!text_in.ready);
    bytes_sent++;
  endtask

  // Sends text_bytes with end_of_text on the final byte.
  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
  endtask

  // Sender holds off until every predicted result is out, then waits on in
  // case a byte that was absorbed is still in the pipe.
  task automatic drain_pause();
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Appends one byte to the text being built.
  function automatic void add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  // Appends one lexical piece: plain bytes, comments, splices, newlines,
  // or noise. Most pieces are well-formed so the comment states get hit.
  task automatic add_token();
    int pick;
    int n;
    pick = $urandom_range(99);
    n    = $urandom_range(3);
    if (pick < 18) begin
      add_byte(8'h61 + 8'($urandom_range(25)));
    end else if (pick < 30) begin
      add_byte(8'($urandom_range(255)));
    end else if (pick < 40) begin
      // line comment, LF or CR LF terminated
      add_byte(cts_pkg::CH_SLASH);
      add_byte(cts_pkg::CH_SLASH);
      repeat (n) add_byte(8'h61 + 8'($urandom_range(25)));
      if ($urandom_range(1)) add_byte(cts_pkg::CH_CR);
      add_byte(cts_pkg::CH_LF);
    end else if (pick < 54) begin
      // block comment, body may carry stars and slashes
      add_byte(cts_pkg::CH_SLASH);
      add_byte(cts_pkg::CH_STAR);
      repeat (n) begin
        case ($urandom_range(3))
          0:       add_byte(cts_pkg::CH_STAR);
          1:       add_byte(cts_pkg::CH_SLASH);
          default: add_byte(8'($urandom_range(255)));
        endcase
      end
      if ($urandom_range(9) != 0) begin
        add_byte(cts_pkg::CH_STAR);
        add_byte(cts_pkg::CH_SLASH);
      end
    end else if (pick < 64) begin
      // line splice, sometimes via CR LF or a lone CR
      add_byte(cts_pkg::CH_BSL);
      case ($urandom_range(2))
        0:       add_byte(cts_pkg::CH_LF);
        1:       add_byte(cts_pkg::CH_CR);
        default: begin
          add_byte(cts_pkg::CH_CR);
          add_byte(cts_pkg::CH_LF);
        end
      endcase
    end else if (pick < 70) begin
      repeat (n + 1) add_byte(cts_pkg::CH_BSL);
    end else if (pick < 80) begin
      case ($urandom_range(2))
        0:       add_byte(cts_pkg::CH_LF);
        1:       add_byte(cts_pkg::CH_CR);
        default: begin
          add_byte(cts_pkg::CH_CR);
          add_byte(cts_pkg::CH_LF);
        end
      endcase
    end else if (pick < 90) begin
      add_byte(cts_pkg::CH_SLASH);
    end else begin
      add_byte(cts_pkg::CH_STAR);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    int pieces;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    target = bytes_sent + BYTES_PER_PHASE;
    while (bytes_sent < target) begin
      pieces = $urandom_range(1, 6);
      repeat (pieces) add_token();
      send_text();
    end
    // Pressure point: stop feeding until the output side has caught up.
    drain_pause();
  endtask

  initial begin
    rst                 = 1'b1;
    text_in.valid       = 1'b0;
    text_in.char_in     = 8'h00;
    text_in.end_of_text = 1'b0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    bytes_sent          = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // CR LF folds to one LF, a lone CR becomes LF.
    text_bytes = {8'h78, cts_pkg::CH_CR, cts_pkg::CH_LF, cts_pkg::CH_CR, 8'h79};
    send_text();
    // Backslash-newline vanishes; byte zero passes through.
    text_bytes = {cts_pkg::CH_BSL, cts_pkg::CH_LF, 8'h00};
    send_text();
    // Spliced line comment runs on to the next line; its newline is kept.
    text_bytes = {cts_pkg::CH_SLASH, cts_pkg::CH_SLASH, cts_pkg::CH_BSL, cts_pkg::CH_LF,
                  8'h64, cts_pkg::CH_LF, 8'h65};
    send_text();
    // The star that opens a block comment does not help close it.
    text_bytes = {cts_pkg::CH_SLASH, cts_pkg::CH_STAR, cts_pkg::CH_SLASH, 8'h78,
                  cts_pkg::CH_STAR, cts_pkg::CH_SLASH};
    send_text();
    // Block comment still open at end of text.
    text_bytes = {cts_pkg::CH_SLASH, cts_pkg::CH_STAR};
    send_text();
    // Held slash and held backslash flushed ahead of 0xFF: four results.
    text_bytes = {cts_pkg::CH_SLASH, cts_pkg::CH_BSL, 8'hFF};
    send_text();
    drain_pause();

    run_phase(0, 0);
    run_phase(74, 0);
    run_phase(0, 74);
    run_phase(36, 36);

    // End of stimulus: drain, then let the pipe settle.
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
